// ===== sv/gss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Golden-section search package
// Slot codes, status flags and fixed-point constants shared by the search
// step logic and the top level.
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int unsigned RATE_W = 16;

  // 0.618 in Q0.16.
  localparam logic [RATE_W-1:0] GOLDEN_Q16 = 16'd40501;

  // Reduction rate after reset: 0.5 in Q0.16.
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd32768;

  typedef enum logic [1:0] {
    SLOT_UPPER  = 2'd0,
    SLOT_MIDDLE = 2'd1,
    SLOT_LOWER  = 2'd2
  } slot_e;

  typedef struct packed {
    logic [2:0] valid;  // indexed by slot code
    logic       done;
  } gss_flags_t;

endpackage

// ===== sv/gss_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition request channel
// Valid/ready channel that carries one evaluated partition per request.
// ----------------------------------------------------------------------------
interface gss_in_if #(
  parameter int unsigned BLOCK_COUNT_BITS = 20,
  parameter int unsigned ENTROPY_BITS     = 48
);
  logic                        valid;
  logic                        ready;
  logic [BLOCK_COUNT_BITS-1:0] new_block_count;
  logic [ENTROPY_BITS-1:0]     new_entropy;

  modport source (output valid, output new_block_count, output new_entropy, input ready);
  modport sink   (input valid, input new_block_count, input new_entropy, output ready);
endinterface

// ===== sv/gss_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search result channel
// Valid/ready channel that carries the next merge step of the search.
// ----------------------------------------------------------------------------
interface gss_out_if #(
  parameter int unsigned BLOCK_COUNT_BITS = 20
);
  logic                        valid;
  logic                        ready;
  logic [BLOCK_COUNT_BITS-1:0] merge_count;
  logic [1:0]                  start_slot;
  logic [BLOCK_COUNT_BITS-1:0] start_block_count;
  logic                        search_done;

  modport source (output valid, output merge_count, output start_slot,
                  output start_block_count, output search_done, input ready);
  modport sink   (input valid, input merge_count, input start_slot,
                  input start_block_count, input search_done, output ready);
endinterface

// ===== sv/gss_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Golden-section search step
// Places one partition into the slot triplet and computes the next merge
// count, start slot and done flag. Purely combinational.
// ----------------------------------------------------------------------------
module gss_step #(
  parameter int unsigned BLOCK_COUNT_BITS = 20,
  parameter int unsigned ENTROPY_BITS     = 48
) (
  input  gss_pkg::gss_flags_t                 flags_i,
  input  logic [2:0][BLOCK_COUNT_BITS-1:0]    cnt_i,
  input  logic [ENTROPY_BITS-1:0]             ent_mid_i,
  input  logic [BLOCK_COUNT_BITS-1:0]         nb_i,
  input  logic [ENTROPY_BITS-1:0]             ne_i,
  input  logic [gss_pkg::RATE_W-1:0]          rate_i,
  output gss_pkg::gss_flags_t                 flags_o,
  output logic [2:0][BLOCK_COUNT_BITS-1:0]    cnt_o,
  output logic [ENTROPY_BITS-1:0]             ent_mid_o,
  output logic [BLOCK_COUNT_BITS-1:0]         merge_o,
  output gss_pkg::slot_e                      slot_o,
  output logic [BLOCK_COUNT_BITS-1:0]         start_cnt_o
);
  import gss_pkg::*;

  localparam int unsigned CB = BLOCK_COUNT_BITS;
  localparam int unsigned DW = CB + 2;
  localparam int unsigned PW = CB + RATE_W;

  gss_flags_t               fl;
  logic [2:0][CB-1:0]       cnt;
  logic [ENTROPY_BITS-1:0]  em;
  logic                     mid_gt;
  logic [CB-1:0]            c0, c1, c2;
  logic signed [DW-1:0]     b0, b1, b2, d01, d12, d02, diff;
  logic                     bracket, tight, up_pick;
  logic [CB-1:0]            d_pos, mul_a, scaled;
  logic [RATE_W-1:0]        mul_b;
  logic [PW-1:0]            prod;
  logic                     done_n;

  // Placement of the new partition. Only the middle slot's entropy is ever
  // compared, and moves only leave the middle, so only that entropy is kept.
  always_comb begin
    cnt    = cnt_i;
    fl     = flags_i;
    em     = ent_mid_i;
    mid_gt = cnt_i[SLOT_MIDDLE] > nb_i;
    if (!flags_i.valid[SLOT_MIDDLE]) begin
      cnt[SLOT_MIDDLE]      = nb_i;
      fl.valid[SLOT_MIDDLE] = 1'b1;
      em                    = ne_i;
    end else if (ne_i <= ent_mid_i) begin
      if (mid_gt) begin
        cnt[SLOT_UPPER]      = cnt_i[SLOT_MIDDLE];
        fl.valid[SLOT_UPPER] = 1'b1;
      end else begin
        cnt[SLOT_LOWER]      = cnt_i[SLOT_MIDDLE];
        fl.valid[SLOT_LOWER] = 1'b1;
      end
      cnt[SLOT_MIDDLE] = nb_i;
      em               = ne_i;
    end else begin
      if (mid_gt) begin
        cnt[SLOT_LOWER]      = nb_i;
        fl.valid[SLOT_LOWER] = 1'b1;
      end else begin
        cnt[SLOT_UPPER]      = nb_i;
        fl.valid[SLOT_UPPER] = 1'b1;
      end
    end
  end

  // Empty slots read as zero blocks.
  assign c0 = fl.valid[SLOT_UPPER]  ? cnt[SLOT_UPPER]  : '0;
  assign c1 = fl.valid[SLOT_MIDDLE] ? cnt[SLOT_MIDDLE] : '0;
  assign c2 = fl.valid[SLOT_LOWER]  ? cnt[SLOT_LOWER]  : '0;

  assign b0 = $signed({2'b00, c0});
  assign b1 = $signed({2'b00, c1});
  assign b2 = $signed({2'b00, c2});

  assign d01 = b0 - b1;
  assign d12 = b1 - b2;
  assign d02 = b0 - b2;

  assign bracket = fl.valid[SLOT_LOWER];
  assign tight   = fl.valid[SLOT_UPPER] ? (d02 == DW'(2)) : (d12 == DW'(1));
  assign up_pick = !(!fl.valid[SLOT_UPPER] && (b1 > b2)) && (d01 >= d12);
  assign diff    = up_pick ? d01 : d12;

  // The golden step leaves hi - lo - trunc(0.618 * (hi - lo)), which has the
  // sign of hi - lo; a non-positive gap therefore saturates to zero merges.
  assign d_pos = (!diff[DW-1] && (diff != '0)) ? diff[CB-1:0] : '0;

  // One multiplier serves both the rate product and the golden step.
  assign mul_a  = bracket ? d_pos : c1;
  assign mul_b  = bracket ? GOLDEN_Q16 : rate_i;
  assign prod   = PW'(mul_a) * PW'(mul_b);
  assign scaled = prod[PW-1:RATE_W];

  assign done_n = flags_i.done | (bracket ? tight : (scaled == '0));

  always_comb begin
    flags_o      = fl;
    flags_o.done = done_n;
    cnt_o        = cnt;
    ent_mid_o    = em;
    if (!bracket) begin
      merge_o = scaled;
      slot_o  = SLOT_MIDDLE;
    end else if (done_n) begin
      merge_o = '0;
      slot_o  = SLOT_MIDDLE;
    end else begin
      merge_o = d_pos - scaled;
      slot_o  = up_pick ? SLOT_UPPER : SLOT_MIDDLE;
    end
    start_cnt_o = (slot_o == SLOT_UPPER) ? c0 : c1;
  end

endmodule

// ===== sv/golden_section_block_count_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Golden-section block count search
// Steers a golden-section search over the number of blocks in a partition.
// ----------------------------------------------------------------------------
// Each request on req_i carries one evaluated partition (block count and
// Q32.16 entropy). The block files it into its upper/middle/lower slots and
// answers on res_o with the merge count for the next iteration, the slot to
// restart from, that slot's block count and the sticky done flag. Exactly
// one result is produced per request, in order.
// A request is registered at acceptance, processed by one pass of placement
// logic and a single shared 16-bit-coefficient multiplier, and the result
// is registered: it moves from the input register to the result register,
// and one request is taken every cycle while res_o is not stalled.
// When res_o is stalled the result register holds, and one further request
// is still taken into the input register; req_i.ready drops only while both
// registers are full. The user must write the reduction rate through
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
// Reset empties all slots, clears done and sets the rate to one half.
// ----------------------------------------------------------------------------
module golden_section_block_count_search #(
  parameter int unsigned BLOCK_COUNT_BITS = 20,
  parameter int unsigned ENTROPY_BITS     = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gss_pkg::RATE_W-1:0]  cfg_wdata_i,
  gss_in_if.sink                      req_i,
  gss_out_if.source                   res_o
);
  import gss_pkg::*;

  localparam int unsigned CB = BLOCK_COUNT_BITS;
  localparam int unsigned EB = ENTROPY_BITS;

  logic                 in_vld_q;
  logic [CB-1:0]        nb_q;
  logic [EB-1:0]        ne_q;
  logic                 out_vld_q;
  logic [CB-1:0]        merge_q, start_q;
  slot_e                slot_q;
  gss_flags_t           flags_q, flags_d;
  logic [2:0][CB-1:0]   cnt_q, cnt_d;
  logic [EB-1:0]        ent_q, ent_d;
  logic [RATE_W-1:0]    rate_q;
  logic [CB-1:0]        merge_d, start_d;
  slot_e                slot_d;
  logic                 advance, fire, in_ready;

  assign advance  = !out_vld_q || res_o.ready;
  assign fire     = in_vld_q && advance;
  assign in_ready = !in_vld_q || advance;

  assign req_i.ready             = in_ready;
  assign res_o.valid             = out_vld_q;
  assign res_o.merge_count       = merge_q;
  assign res_o.start_slot        = 2'(slot_q);
  assign res_o.start_block_count = start_q;
  assign res_o.search_done       = flags_q.done;

  gss_step #(
    .BLOCK_COUNT_BITS (CB),
    .ENTROPY_BITS     (EB)
  ) u_step (
    .flags_i     (flags_q),
    .cnt_i       (cnt_q),
    .ent_mid_i   (ent_q),
    .nb_i        (nb_q),
    .ne_i        (ne_q),
    .rate_i      (rate_q),
    .flags_o     (flags_d),
    .cnt_o       (cnt_d),
    .ent_mid_o   (ent_d),
    .merge_o     (merge_d),
    .slot_o      (slot_d),
    .start_cnt_o (start_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      flags_q   <= '0;
      rate_q    <= RATE_RESET;
    end else begin
      if (in_ready) begin
        in_vld_q <= req_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        flags_q <= flags_d;
      end
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers; slot contents are qualified by the valid flags.
  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      nb_q <= req_i.new_block_count;
      ne_q <= req_i.new_entropy;
    end
    if (fire) begin
      cnt_q   <= cnt_d;
      ent_q   <= ent_d;
      merge_q <= merge_d;
      slot_q  <= slot_d;
      start_q <= start_d;
    end
  end

endmodule
